/* hdl/sfs_pkg.sv */
// shared constants for the sensor frame serializer
package sfs_pkg;

	// frame layout
	localparam int FRAME_LEN  = 16;
	localparam int DATA_BYTES = 14;
	localparam int CNT_W      = $clog2(FRAME_LEN);
	localparam int CHK_HI_IDX = DATA_BYTES;
	localparam int CHK_LO_IDX = FRAME_LEN - 1;

	// checksum of fourteen bytes never exceeds 14 * 255
	localparam int CHK_W = $clog2(DATA_BYTES * 255 + 1);

	// divide by ten through reciprocal multiply, exact for 16-bit values
	localparam int          RECIP_SHIFT = 19;
	localparam logic [15:0] RECIP       = 16'hCCCD;
	localparam int          QUOT_W      = 32 - RECIP_SHIFT;

	// configuration register indexes
	localparam int IDX_W = 8;
	localparam logic [IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
	localparam logic [IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

endpackage

/* hdl/sfs_tenths.sv */
// splits a value in tenths into a whole byte and a tenths byte
module sfs_tenths (
	input  logic [15:0] value,
	output logic [7:0]  whole,
	output logic [7:0]  frac
);

	logic [31:0]                 prod;
	logic [sfs_pkg::QUOT_W-1:0]  quot;
	logic [16:0]                 quot_x10;
	logic [3:0]                  rem;

	// quotient by ten via reciprocal multiply
	assign prod = 32'(value) * 32'(sfs_pkg::RECIP);
	assign quot = prod[31:sfs_pkg::RECIP_SHIFT];

	// remainder from quotient times ten
	assign quot_x10 = 17'({quot, 3'b000}) + 17'({quot, 1'b0});
	assign rem      = 4'(17'(value) - quot_x10);

	// whole part keeps its low byte, tenths scaled by ten
	assign whole = quot[7:0];
	assign frac  = {1'b0, rem, 3'b000} + {3'b000, rem, 1'b0};

endmodule

/* hdl/sensor_frame_serializer_core.sv */
// sensor frame serializer top level: input register, frame shifter, running checksum
// first frame byte strobes after the item moves from the input register to the shifter
// throughput: one frame byte per cycle; frames run back to back when the next item waits
// an item is taken while the previous frame is still streaming; the 16-byte frame sets the rate
// the receiver cannot stall; every byte is shown for exactly one cycle
// reset clears pipeline control and both header registers to zero
module sensor_frame_serializer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// item input
	input  logic                      start,
	output logic                      busy,
	input  logic [15:0]               fine_dust,
	input  logic [15:0]               coarse_dust,
	input  logic [15:0]               carbon_dioxide,
	input  logic [15:0]               formaldehyde,
	input  logic [15:0]               temperature_tenths,
	input  logic [15:0]               humidity_tenths,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sfs_pkg::IDX_W-1:0] cfg_index,
	input  logic [7:0]                cfg_data,
	// frame output
	output logic                      frame_valid,
	output logic [7:0]                frame_byte,
	output logic                      frame_end
);

	logic       accept;
	logic       load_s2;
	logic       valid_s1;
	logic [15:0] fine_s1, coarse_s1, co2_s1, form_s1, temp_s1, hum_s1;

	logic [7:0] header_first_q;
	logic [7:0] header_second_q;

	logic [7:0] temp_whole, temp_frac, hum_whole, hum_frac;
	logic [7:0] next_frame [sfs_pkg::DATA_BYTES];

	logic [7:0]                 frame_s2 [sfs_pkg::DATA_BYTES];
	logic                       active_q;
	logic [sfs_pkg::CNT_W-1:0]  cnt_q;
	logic [sfs_pkg::CHK_W-1:0]  sum_q;
	logic                       last_byte;

	// handshake
	assign last_byte = (cnt_q == sfs_pkg::CNT_W'(sfs_pkg::CHK_LO_IDX));
	assign load_s2   = valid_s1 && (!active_q || last_byte);
	assign busy      = valid_s1 && !load_s2;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= '0;
			header_second_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sfs_pkg::REG_HEADER_FIRST) begin
				header_first_q <= cfg_data;
			end else if (cfg_index == sfs_pkg::REG_HEADER_SECOND) begin
				header_second_q <= cfg_data;
			end
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fine_s1   <= fine_dust;
			coarse_s1 <= coarse_dust;
			co2_s1    <= carbon_dioxide;
			form_s1   <= formaldehyde;
			temp_s1   <= temperature_tenths;
			hum_s1    <= humidity_tenths;
		end
	end

	// whole and tenths bytes
	sfs_tenths u_temp_tenths (
		.value (temp_s1),
		.whole (temp_whole),
		.frac  (temp_frac)
	);

	sfs_tenths u_hum_tenths (
		.value (hum_s1),
		.whole (hum_whole),
		.frac  (hum_frac)
	);

	// frame bytes ahead of the checksum in transmit order
	always_comb begin
		next_frame[0]  = header_first_q;
		next_frame[1]  = header_second_q;
		next_frame[2]  = fine_s1[15:8];
		next_frame[3]  = fine_s1[7:0];
		next_frame[4]  = coarse_s1[15:8];
		next_frame[5]  = coarse_s1[7:0];
		next_frame[6]  = co2_s1[15:8];
		next_frame[7]  = co2_s1[7:0];
		next_frame[8]  = form_s1[15:8];
		next_frame[9]  = form_s1[7:0];
		next_frame[10] = temp_whole;
		next_frame[11] = temp_frac;
		next_frame[12] = hum_whole;
		next_frame[13] = hum_frac;
	end

	// frame sequencing and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
		end else if (load_s2) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
			sum_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_byte) begin
				active_q <= 1'b0;
			end
			if (cnt_q < sfs_pkg::CNT_W'(sfs_pkg::DATA_BYTES)) begin
				sum_q <= sum_q + sfs_pkg::CHK_W'(frame_byte);
			end
		end
	end

	// frame shifter payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			frame_s2 <= next_frame;
		end else if (active_q) begin
			for (int i = 0; i < sfs_pkg::DATA_BYTES - 1; i++) begin
				frame_s2[i] <= frame_s2[i+1];
			end
		end
	end

	// output byte select
	always_comb begin
		priority if (cnt_q == sfs_pkg::CNT_W'(sfs_pkg::CHK_HI_IDX)) begin
			frame_byte = 8'(sum_q >> 8);
		end else if (last_byte) begin
			frame_byte = sum_q[7:0];
		end else begin
			frame_byte = frame_s2[0];
		end
	end

	assign frame_valid = active_q;
	assign frame_end   = active_q && last_byte;

	// checks
	a_end_is_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end |-> frame_valid)
		else $error("frame end outside a strobed byte");

	a_frame_gap_free: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_end |=> frame_valid)
		else $error("gap inside a frame");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item not held in input register");

	a_first_byte_header: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && (cnt_q == '0) |-> frame_byte == header_first_q)
		else $error("frame does not open with the first header byte");

endmodule

/* sim/sensor_frame_serializer_core_tb.sv */
// testbench for the sensor frame serializer: directed and random reading sets, byte-level frame check
module sensor_frame_serializer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct packed {
		logic [15:0] fine_dust;
		logic [15:0] coarse_dust;
		logic [15:0] carbon_dioxide;
		logic [15:0] formaldehyde;
		logic [15:0] temperature_tenths;
		logic [15:0] humidity_tenths;
	} reading_set_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_slot_t;

	// frame predictor and in-order byte checker
	class frame_scoreboard;
		logic [7:0]  hdr_first;
		logic [7:0]  hdr_second;
		frame_slot_t frame_bytes_due[$];
		int          errors;
		int          bytes_checked;
		int          frames_noted;

		function new();
			hdr_first = 8'h00;
			hdr_second = 8'h00;
			errors = 0;
			bytes_checked = 0;
			frames_noted = 0;
		endfunction

		function void write_header(logic [sfs_pkg::IDX_W-1:0] idx, logic [7:0] data);
			if (idx == sfs_pkg::REG_HEADER_FIRST) begin
				hdr_first = data;
			end else if (idx == sfs_pkg::REG_HEADER_SECOND) begin
				hdr_second = data;
			end
		endfunction

		function logic [7:0] whole_part(logic [15:0] v);
			logic [15:0] q;
			q = v / 16'd10;
			return q[7:0];
		endfunction

		function logic [7:0] tenths_digit(logic [15:0] v);
			logic [15:0] m;
			m = (v % 16'd10) * 16'd10;
			return m[7:0];
		endfunction

		// build the expected bytes of one reading set
		function void note_readings(reading_set_t r);
			logic [7:0]  seq [0:sfs_pkg::FRAME_LEN-1];
			logic [15:0] sum;
			frame_slot_t slot;
			seq[0] = hdr_first;
			seq[1] = hdr_second;
			seq[2] = r.fine_dust[15:8];
			seq[3] = r.fine_dust[7:0];
			seq[4] = r.coarse_dust[15:8];
			seq[5] = r.coarse_dust[7:0];
			seq[6] = r.carbon_dioxide[15:8];
			seq[7] = r.carbon_dioxide[7:0];
			seq[8] = r.formaldehyde[15:8];
			seq[9] = r.formaldehyde[7:0];
			seq[10] = whole_part(r.temperature_tenths);
			seq[11] = tenths_digit(r.temperature_tenths);
			seq[12] = whole_part(r.humidity_tenths);
			seq[13] = tenths_digit(r.humidity_tenths);
			sum = 16'h0000;
			for (int i = 0; i < sfs_pkg::DATA_BYTES; i++) begin
				sum = sum + {8'h00, seq[i]};
			end
			seq[sfs_pkg::CHK_HI_IDX] = sum[15:8];
			seq[sfs_pkg::CHK_LO_IDX] = sum[7:0];
			for (int i = 0; i < sfs_pkg::FRAME_LEN; i++) begin
				slot.value = seq[i];
				slot.last = (i == sfs_pkg::CHK_LO_IDX);
				frame_bytes_due.push_back(slot);
			end
			frames_noted++;
		endfunction

		// compare one strobed byte with the oldest expected one
		function void check_byte(logic [7:0] b, logic e);
			frame_slot_t want;
			if (frame_bytes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected frame byte, actual byte %02h end %0b", $time, b, e);
				return;
			end
			want = frame_bytes_due.pop_front();
			bytes_checked++;
			if (b !== want.value) begin
				errors++;
				$display("%0t: frame_byte mismatch, expected %02h actual %02h",
					$time, want.value, b);
			end
			if (e !== want.last) begin
				errors++;
				$display("%0t: frame_end mismatch, expected %0b actual %0b",
					$time, want.last, e);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	reading_set_t              current;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [sfs_pkg::IDX_W-1:0] cfg_index;
	logic [7:0]                cfg_data;
	logic                      frame_valid;
	logic [7:0]                frame_byte;
	logic                      frame_end;

	frame_scoreboard sb;
	int              cycle_count;
	int              config_writes;

	sensor_frame_serializer_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.fine_dust          (current.fine_dust),
		.coarse_dust        (current.coarse_dust),
		.carbon_dioxide     (current.carbon_dioxide),
		.formaldehyde       (current.formaldehyde),
		.temperature_tenths (current.temperature_tenths),
		.humidity_tenths    (current.humidity_tenths),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.frame_valid        (frame_valid),
		.frame_byte         (frame_byte),
		.frame_end          (frame_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// monitor: accepted items, register writes and frame bytes
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_readings(current);
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_header(cfg_index, cfg_data);
			end
			if (frame_valid) begin
				sb.check_byte(frame_byte, frame_end);
			end
		end
	end

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(2550 + $urandom_range(0, 19));
			3: return 16'($urandom_range(0, 999));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic reading_set_t random_readings();
		reading_set_t r;
		r.fine_dust = pick_word();
		r.coarse_dust = pick_word();
		r.carbon_dioxide = pick_word();
		r.formaldehyde = pick_word();
		r.temperature_tenths = pick_word();
		r.humidity_tenths = pick_word();
		return r;
	endfunction

	function automatic reading_set_t make_set(logic [15:0] fd, logic [15:0] cd,
		logic [15:0] co2, logic [15:0] fm, logic [15:0] t, logic [15:0] h);
		reading_set_t r;
		r.fine_dust = fd;
		r.coarse_dust = cd;
		r.carbon_dioxide = co2;
		r.formaldehyde = fm;
		r.temperature_tenths = t;
		r.humidity_tenths = h;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 12) return 0;
		else if (sel < 18) return $urandom_range(1, 3);
		else return $urandom_range(10, 45);
	endfunction

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_item(input reading_set_t r);
		current = r;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// hold start low with junk on the data ports
	task automatic idle_gap(input int n);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) begin
				current = random_readings();
				@(negedge clk);
			end
		end
	endtask

	// register write once every frame byte has been seen
	task automatic write_register(input logic [sfs_pkg::IDX_W-1:0] idx,
		input logic [7:0] data);
		start = 1'b0;
		while (sb.frame_bytes_due.size() != 0 || busy) @(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_index = sfs_pkg::IDX_W'($urandom);
		cfg_data = 8'($urandom);
		config_writes++;
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		config_writes = 0;
		arst_n = 1'b0;
		start = 1'b0;
		current = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = 8'h00;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset headers, field extremes, whole-part truncation
		send_item(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0));
		send_item(make_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		idle_gap(1);
		send_item(make_set(16'hAAAA, 16'h5555, 16'hA5A5, 16'h5A5A, 16'd9, 16'd99));
		send_item(make_set(16'h00FF, 16'hFF00, 16'h0001, 16'h8000, 16'd2559, 16'd2560));
		idle_gap(3);
		send_item(make_set(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'd2569, 16'd2550));

		// directed: headers at their top value, near-maximum checksum
		write_register(sfs_pkg::REG_HEADER_FIRST, 8'hFF);
		write_register(sfs_pkg::REG_HEADER_SECOND, 8'hFF);
		send_item(make_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2559, 16'd2559));
		send_item(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd10, 16'd1));

		// directed: writes to unmapped indexes must not disturb the headers
		write_register(sfs_pkg::REG_HEADER_FIRST, 8'hA5);
		write_register(sfs_pkg::REG_HEADER_SECOND, 8'h5A);
		write_register(8'h02, 8'h3C);
		write_register(8'hFF, 8'hC3);
		write_register(8'h80, 8'h00);
		send_item(make_set(16'h5555, 16'hAAAA, 16'h5A5A, 16'hA5A5, 16'd65534, 16'd65535));
		idle_gap(2);
		send_item(make_set(16'h0100, 16'h00FE, 16'h7FFF, 16'h8001, 16'd90, 16'd2565));
		send_item(make_set(16'hFFFE, 16'h0001, 16'hFF01, 16'h01FF, 16'd1, 16'd0));

		// random phases, each under its own header setting
		for (int p = 0; p < 6; p++) begin
			if (p == 0) begin
				write_register(sfs_pkg::REG_HEADER_FIRST, 8'h00);
				write_register(sfs_pkg::REG_HEADER_SECOND, 8'hFF);
			end else if (p == 5) begin
				write_register(sfs_pkg::REG_HEADER_FIRST, 8'hFF);
				write_register(sfs_pkg::REG_HEADER_SECOND, 8'h00);
			end else begin
				write_register(sfs_pkg::REG_HEADER_FIRST, 8'($urandom));
				if ($urandom_range(0, 1) == 1) begin
					write_register(sfs_pkg::IDX_W'($urandom_range(2, 255)), 8'($urandom));
				end
				write_register(sfs_pkg::REG_HEADER_SECOND, 8'($urandom));
			end
			repeat (42) begin
				// phase two runs with no idling at all
				idle_gap((p == 2) ? 0 : pick_gap());
				send_item(random_readings());
			end
		end

		// drain
		start = 1'b0;
		while (sb.frame_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d reading sets framed, %0d frame bytes checked",
			sb.frames_noted, sb.bytes_checked);
		$display("%0d register writes, including unmapped indexes and header extremes",
			config_writes);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/sfs_pkg.sv
hdl/sfs_tenths.sv
hdl/sensor_frame_serializer_core.sv
sim/sensor_frame_serializer_core_tb.sv
